@@ rtl/smap_pkg.sv @@
package smap_pkg;

    localparam int NUM_SLOTS   = 1024;
    localparam int POS_W       = 10;
    localparam int CNT_W       = 11;
    localparam int WORD_W      = 32;
    localparam int WORD_BITS_W = $clog2(WORD_W);
    localparam int NUM_WORDS   = NUM_SLOTS / WORD_W;
    localparam int WADDR_W     = $clog2(NUM_WORDS);
    localparam int POP_W       = $clog2(WORD_W) + 1;
    localparam int POS_REACH   = 1 << POS_W;
    localparam int MAX_N       = (NUM_SLOTS < POS_REACH) ? NUM_SLOTS : POS_REACH;

    localparam logic [1:0] ST_PLACED  = 2'd0;
    localparam logic [1:0] ST_NOFREE  = 2'd1;
    localparam logic [1:0] ST_CLEARED = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    localparam logic ACT_PLACE = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0]      new_word;
        logic [POP_W-1:0]       cnt;
        logic                   any;
        logic [WORD_BITS_W-1:0] first_bit;
        logic [WORD_BITS_W-1:0] last_bit;
    } word_res_t;

endpackage

@@ rtl/slot_fill_and_clear_map.sv @@
// Slot occupancy map held in a 32-word by 32-bit synchronous RAM, all slots
// free after reset. A place request fills free slots from start_pos upward;
// a clear request counts and frees occupied slots in start_pos..end_pos. Each
// request visits the words of its range one at a time, each with a RAM read
// in S_READ, then an update and write back in S_PROC, after an accepting
// step in S_IDLE and before S_DONE loads the output register. A request
// flagged as bad goes from S_IDLE straight to S_DONE, and S_DONE waits until
// the previous result has been taken. One request is worked on at a
// time; the next is taken as soon as the result sits in the output register.
// Per-word valid flags stand for the reset contents, so no clearing pass is
// needed.
module slot_fill_and_clear_map (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [smap_pkg::CNT_W-1:0]  cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_action,
    input  logic [smap_pkg::POS_W-1:0]  s_start_pos,
    input  logic [smap_pkg::CNT_W-1:0]  s_amount,
    input  logic [smap_pkg::POS_W-1:0]  s_end_pos,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [smap_pkg::POS_W-1:0]  m_first_slot,
    output logic [smap_pkg::POS_W-1:0]  m_last_slot,
    output logic [smap_pkg::CNT_W-1:0]  m_freed_count
);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_PROC, S_DONE} state_t;

    state_t                        state_reg;
    logic [smap_pkg::CNT_W-1:0]    cfg_reg;
    logic [smap_pkg::NUM_WORDS-1:0] valid_reg;
    logic                          action_reg;
    logic                          bad_reg;
    logic                          found_reg;
    logic [smap_pkg::CNT_W-1:0]    lo_reg;
    logic [smap_pkg::CNT_W-1:0]    hi_reg;
    logic [smap_pkg::CNT_W-1:0]    amount_reg;
    logic [smap_pkg::CNT_W-1:0]    got_reg;
    logic [smap_pkg::WADDR_W-1:0]  widx_reg;
    logic [smap_pkg::POS_W-1:0]    first_reg;
    logic [smap_pkg::POS_W-1:0]    last_reg;
    logic                          m_valid_reg;
    logic [1:0]                    m_status_reg;
    logic [smap_pkg::POS_W-1:0]    m_first_reg;
    logic [smap_pkg::POS_W-1:0]    m_last_reg;
    logic [smap_pkg::CNT_W-1:0]    m_freed_reg;

    logic [smap_pkg::CNT_W-1:0]    n;
    logic [smap_pkg::CNT_W-1:0]    start_ext;
    logic [smap_pkg::CNT_W-1:0]    end_eff;
    logic                          req_bad;
    logic [smap_pkg::WORD_W-1:0]   rd_data;
    logic [smap_pkg::WORD_W-1:0]   cur_word;
    logic [smap_pkg::WADDR_W-1:0]  last_widx;
    smap_pkg::word_res_t           wres;
    logic [smap_pkg::POS_W-1:0]    word_base;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_first_slot  = m_first_reg;
    assign m_last_slot   = m_last_reg;
    assign m_freed_count = m_freed_reg;

    always_comb begin
        n = (cfg_reg > smap_pkg::CNT_W'(smap_pkg::MAX_N)) ?
            smap_pkg::CNT_W'(smap_pkg::MAX_N) : cfg_reg;
        start_ext = smap_pkg::CNT_W'(s_start_pos);
        end_eff = (smap_pkg::CNT_W'(s_end_pos) >= n) ? (n - 1'b1)
                                                     : smap_pkg::CNT_W'(s_end_pos);
        if (start_ext >= n) begin
            req_bad = 1'b1;
        end else if (s_action == smap_pkg::ACT_PLACE) begin
            req_bad = (s_amount == '0);
        end else begin
            req_bad = (start_ext > end_eff);
        end
    end

    assign cur_word  = valid_reg[widx_reg] ? rd_data : '0;
    assign last_widx = smap_pkg::WADDR_W'(hi_reg >> smap_pkg::WORD_BITS_W);
    assign word_base = smap_pkg::POS_W'(smap_pkg::CNT_W'(widx_reg) << smap_pkg::WORD_BITS_W);

    smap_word u_word (
        .word      (cur_word),
        .widx      (widx_reg),
        .action    (action_reg),
        .lo        (lo_reg),
        .hi        (hi_reg),
        .remaining (amount_reg - got_reg),
        .res       (wres)
    );

    smap_ram #(
        .DEPTH (smap_pkg::NUM_WORDS),
        .WIDTH (smap_pkg::WORD_W)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (state_reg == S_READ),
        .rd_addr (widx_reg),
        .rd_data (rd_data),
        .wr_en   (state_reg == S_PROC),
        .wr_addr (widx_reg),
        .wr_data (wres.new_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cfg_reg     <= smap_pkg::CNT_W'(1024);
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cfg_reg <= cfg_data;
            end
            // In S_DONE the output register is reloaded whenever it is empty or its word is taken.
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        action_reg <= s_action;
                        bad_reg    <= req_bad;
                        found_reg  <= 1'b0;
                        got_reg    <= '0;
                        first_reg  <= '0;
                        last_reg   <= '0;
                        amount_reg <= s_amount;
                        lo_reg     <= start_ext;
                        hi_reg     <= (s_action == smap_pkg::ACT_PLACE) ? (n - 1'b1)
                                                                        : end_eff;
                        widx_reg   <= smap_pkg::WADDR_W'(s_start_pos >>
                                                         smap_pkg::WORD_BITS_W);
                        state_reg  <= req_bad ? S_DONE : S_READ;
                    end
                end
                S_READ: begin
                    state_reg <= S_PROC;
                end
                S_PROC: begin
                    valid_reg[widx_reg] <= 1'b1;
                    got_reg <= got_reg + smap_pkg::CNT_W'(wres.cnt);
                    if (wres.any) begin
                        last_reg <= word_base | smap_pkg::POS_W'(wres.last_bit);
                        if (!found_reg) begin
                            first_reg <= word_base | smap_pkg::POS_W'(wres.first_bit);
                            found_reg <= 1'b1;
                        end
                    end
                    if (widx_reg == last_widx) begin
                        state_reg <= S_DONE;
                    end else begin
                        widx_reg  <= widx_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_first_reg <= '0;
                        m_last_reg  <= '0;
                        m_freed_reg <= '0;
                        if (bad_reg) begin
                            m_status_reg <= smap_pkg::ST_BAD;
                        end else if (action_reg == smap_pkg::ACT_CLEAR) begin
                            m_status_reg <= smap_pkg::ST_CLEARED;
                            m_freed_reg  <= got_reg;
                        end else if (got_reg == '0) begin
                            m_status_reg <= smap_pkg::ST_NOFREE;
                        end else begin
                            m_status_reg <= smap_pkg::ST_PLACED;
                            m_first_reg  <= first_reg;
                            m_last_reg   <= last_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/smap_ram.sv @@
module smap_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/smap_word.sv @@
module smap_word (
    input  logic [smap_pkg::WORD_W-1:0]  word,
    input  logic [smap_pkg::WADDR_W-1:0] widx,
    input  logic                         action,
    input  logic [smap_pkg::CNT_W-1:0]   lo,
    input  logic [smap_pkg::CNT_W-1:0]   hi,
    input  logic [smap_pkg::CNT_W-1:0]   remaining,
    output smap_pkg::word_res_t          res
);

    logic [smap_pkg::WORD_W-1:0] in_range;
    logic [smap_pkg::WORD_W-1:0] free_bits;
    logic [smap_pkg::WORD_W-1:0] sel;
    logic [smap_pkg::WORD_W-1:0] hit;

    always_comb begin
        logic [smap_pkg::CNT_W-1:0] pos;
        logic [smap_pkg::WORD_W-1:0] low_mask;
        for (int i = 0; i < smap_pkg::WORD_W; i++) begin
            pos = (smap_pkg::CNT_W'(widx) << smap_pkg::WORD_BITS_W)
                  | smap_pkg::CNT_W'(i);
            in_range[i] = (pos >= lo) && (pos <= hi);
        end
        free_bits = ~word & in_range;
        // A free slot is taken while its rank among free slots fits the request.
        for (int i = 0; i < smap_pkg::WORD_W; i++) begin
            low_mask = {smap_pkg::WORD_W{1'b1}} >> (smap_pkg::WORD_W - 1 - i);
            sel[i] = free_bits[i] &&
                     (smap_pkg::CNT_W'($countones(free_bits & low_mask)) <= remaining);
        end
        hit = (action == smap_pkg::ACT_CLEAR) ? (word & in_range) : sel;

        res.new_word = (action == smap_pkg::ACT_CLEAR) ? (word & ~in_range)
                                                       : (word | sel);
        res.cnt = smap_pkg::POP_W'($countones(hit));
        res.any = |sel;
        res.first_bit = '0;
        res.last_bit = '0;
        for (int i = smap_pkg::WORD_W - 1; i >= 0; i--) begin
            if (sel[i]) begin
                res.first_bit = smap_pkg::WORD_BITS_W'(i);
            end
        end
        for (int i = 0; i < smap_pkg::WORD_W; i++) begin
            if (sel[i]) begin
                res.last_bit = smap_pkg::WORD_BITS_W'(i);
            end
        end
    end

endmodule

@@ rtl/smap_checker.sv @@
module smap_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [1:0]                 m_status,
    input logic [smap_pkg::POS_W-1:0] m_first_slot,
    input logic [smap_pkg::POS_W-1:0] m_last_slot,
    input logic [smap_pkg::CNT_W-1:0] m_freed_count
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result word dropped or changed while stalled");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == smap_pkg::ST_PLACED |-> m_first_slot <= m_last_slot)
        else $error("placed range runs backward");

    a_freed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != smap_pkg::ST_CLEARED |-> m_freed_count == '0)
        else $error("freed count set on a non-clear result");

    a_slots: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != smap_pkg::ST_PLACED |->
        m_first_slot == '0 && m_last_slot == '0)
        else $error("slot positions set on a non-place result");

endmodule

bind slot_fill_and_clear_map smap_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_first_slot  (m_first_slot),
    .m_last_slot   (m_last_slot),
    .m_freed_count (m_freed_count)
);
